/* src/dnsa_pkg.sv */
package dnsa_pkg;

  localparam int unsigned MaxBytes  = 512;
  localparam int unsigned MaxLabels = 64;
  localparam int unsigned CntW      = 10;
  localparam int unsigned HopW      = 7;

  localparam logic [7:0]  PtrMask   = 8'hC0;
  localparam logic [7:0]  RcodeMask = 8'h0F;
  localparam logic [15:0] QFixLen   = 16'd4;
  localparam logic [15:0] AFixLen   = 16'd10;
  localparam logic [15:0] TypeA     = 16'd1;
  localparam logic [15:0] ClassIn   = 16'd1;
  localparam logic [15:0] Ipv4Len   = 16'd4;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } item_t;

  typedef struct packed {
    logic        found;
    logic [31:0] ip;
  } res_t;

endpackage

/* src/dnsa_in_reg.sv */
module dnsa_in_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic [7:0]     data_byte_i,
  input  logic           last_byte_i,
  output logic           in_stall_o,
  input  logic           drain_i,
  output logic           vld_o,
  output dnsa_pkg::item_t item_o
);

  logic            vld_q, vld_d;
  dnsa_pkg::item_t item_q;
  logic            load;

  assign in_stall_o = vld_q & ~drain_i;
  assign load       = in_valid_i & ~in_stall_o;
  assign vld_d      = load | (vld_q & ~drain_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q.data <= data_byte_i;
      item_q.last <= last_byte_i;
    end
  end

  assign vld_o  = vld_q;
  assign item_o = item_q;

  a_drain_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drain_i |-> vld_q) else $error("drain without a held byte");

endmodule

/* src/dnsa_parse.sv */
module dnsa_parse (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [15:0]     cfg_wdata_i,
  input  logic            take_i,
  input  dnsa_pkg::item_t item_i,
  output logic            res_vld_o,
  output dnsa_pkg::res_t  res_o
);

  localparam logic [3:0] PhHdr   = 4'd0;
  localparam logic [3:0] PhQLen  = 4'd1;
  localparam logic [3:0] PhQBody = 4'd2;
  localparam logic [3:0] PhQPtr  = 4'd3;
  localparam logic [3:0] PhQFix  = 4'd4;
  localparam logic [3:0] PhALen  = 4'd5;
  localparam logic [3:0] PhABody = 4'd6;
  localparam logic [3:0] PhAPtr  = 4'd7;
  localparam logic [3:0] PhAFix  = 4'd8;
  localparam logic [3:0] PhRdata = 4'd9;
  localparam logic [3:0] PhOk    = 4'd10;
  localparam logic [3:0] PhFail  = 4'd11;

  logic [15:0]                   exp_id_q;
  logic [3:0]                    phase_q, phase_d;
  logic [dnsa_pkg::CntW-1:0]     cnt_q, cnt_d;
  logic [15:0]                   fl_q, fl_d;
  logic [15:0]                   ans_q, ans_d;
  logic [dnsa_pkg::HopW-1:0]     hops_q, hops_d;
  logic [15:0]                   rtype_q, rtype_d;
  logic [15:0]                   rclass_q, rclass_d;
  logic [15:0]                   rdlen_q, rdlen_d;
  logic [31:0]                   acc_q, acc_d;
  logic                          res_vld_d;
  dnsa_pkg::res_t                res_d;

  logic [7:0]  c;
  logic        in_q_name;
  logic [3:0]  base;
  logic [15:0] fl_dec;
  logic [15:0] ans_dec;
  logic [15:0] rdlen_new;

  assign c         = item_i.data;
  assign in_q_name = (phase_q == PhQLen) || (phase_q == PhQBody) || (phase_q == PhQPtr);
  assign base      = in_q_name ? PhQLen : PhALen;
  assign fl_dec    = fl_q - 16'd1;
  assign ans_dec   = ans_q - 16'd1;
  assign rdlen_new = {rdlen_q[15:8], c};

  always_comb begin
    phase_d   = phase_q;
    cnt_d     = cnt_q;
    fl_d      = fl_q;
    ans_d     = ans_q;
    hops_d    = hops_q;
    rtype_d   = rtype_q;
    rclass_d  = rclass_q;
    rdlen_d   = rdlen_q;
    acc_d     = acc_q;
    res_vld_d = 1'b0;
    res_d     = '0;

    if (take_i) begin
      if (cnt_q < dnsa_pkg::CntW'(dnsa_pkg::MaxBytes)) begin
        cnt_d = cnt_q + 1'b1;
        unique case (phase_q)
          PhHdr: begin
            if (cnt_q == 10'd0 && c != exp_id_q[15:8]) begin
              phase_d = PhFail;
            end else if (cnt_q == 10'd1 && c != exp_id_q[7:0]) begin
              phase_d = PhFail;
            end else if (cnt_q == 10'd3 && (c & dnsa_pkg::RcodeMask) != 8'd0) begin
              phase_d = PhFail;
            end else if (cnt_q == 10'd6) begin
              ans_d = {c, 8'd0};
            end else if (cnt_q == 10'd7) begin
              ans_d = {ans_q[15:8], c};
            end else if (cnt_q == 10'd11) begin
              if (ans_q == 16'd0) begin
                phase_d = PhFail;
              end else begin
                phase_d = PhQLen;
                hops_d  = '0;
              end
            end
          end
          PhQLen, PhALen: begin
            if (hops_q >= dnsa_pkg::HopW'(dnsa_pkg::MaxLabels)) begin
              phase_d = PhFail;
            end else begin
              hops_d = hops_q + 1'b1;
              if (c == 8'd0) begin
                if (base == PhQLen) begin
                  phase_d = PhQFix;
                  fl_d    = dnsa_pkg::QFixLen;
                end else begin
                  phase_d = PhAFix;
                  fl_d    = dnsa_pkg::AFixLen;
                end
              end else if ((c & dnsa_pkg::PtrMask) == dnsa_pkg::PtrMask) begin
                phase_d = base + 4'd2;
              end else begin
                fl_d    = {8'd0, c};
                phase_d = base + 4'd1;
              end
            end
          end
          PhQBody, PhABody: begin
            fl_d = fl_dec;
            if (fl_dec == 16'd0) begin
              phase_d = base;
            end
          end
          PhQPtr: begin
            phase_d = PhQFix;
            fl_d    = dnsa_pkg::QFixLen;
          end
          PhAPtr: begin
            phase_d = PhAFix;
            fl_d    = dnsa_pkg::AFixLen;
          end
          PhQFix: begin
            fl_d = fl_dec;
            if (fl_dec == 16'd0) begin
              phase_d = PhALen;
              hops_d  = '0;
            end
          end
          PhAFix: begin
            if (fl_q == 16'd10) rtype_d  = {c, 8'd0};
            if (fl_q == 16'd9)  rtype_d  = {rtype_q[15:8], c};
            if (fl_q == 16'd8)  rclass_d = {c, 8'd0};
            if (fl_q == 16'd7)  rclass_d = {rclass_q[15:8], c};
            if (fl_q == 16'd2)  rdlen_d  = {c, 8'd0};
            if (fl_q == 16'd1)  rdlen_d  = rdlen_new;
            fl_d = fl_dec;
            if (fl_dec == 16'd0) begin
              if (rdlen_new == 16'd0) begin
                ans_d = ans_dec;
                if (ans_dec == 16'd0) begin
                  phase_d = PhFail;
                end else begin
                  phase_d = PhALen;
                  hops_d  = '0;
                end
              end else begin
                phase_d = PhRdata;
                fl_d    = rdlen_new;
                acc_d   = '0;
              end
            end
          end
          PhRdata: begin
            acc_d = {acc_q[23:0], c};
            fl_d  = fl_dec;
            if (fl_dec == 16'd0) begin
              if (rtype_q == dnsa_pkg::TypeA && rclass_q == dnsa_pkg::ClassIn &&
                  rdlen_q == dnsa_pkg::Ipv4Len) begin
                phase_d = PhOk;
              end else begin
                ans_d = ans_dec;
                if (ans_dec == 16'd0) begin
                  phase_d = PhFail;
                end else begin
                  phase_d = PhALen;
                  hops_d  = '0;
                end
              end
            end
          end
          default: begin
          end
        endcase
      end

      if (item_i.last) begin
        res_vld_d = 1'b1;
        res_d.found = (phase_d == PhOk);
        res_d.ip    = (phase_d == PhOk) ? acc_d : 32'd0;
        phase_d  = PhHdr;
        cnt_d    = '0;
        fl_d     = '0;
        ans_d    = '0;
        hops_d   = '0;
        rtype_d  = '0;
        rclass_d = '0;
        rdlen_d  = '0;
        acc_d    = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_id_q <= '0;
      phase_q  <= PhHdr;
      cnt_q    <= '0;
      fl_q     <= '0;
      ans_q    <= '0;
      hops_q   <= '0;
      rtype_q  <= '0;
      rclass_q <= '0;
      rdlen_q  <= '0;
      acc_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        exp_id_q <= cfg_wdata_i;
      end
      phase_q  <= phase_d;
      cnt_q    <= cnt_d;
      fl_q     <= fl_d;
      ans_q    <= ans_d;
      hops_q   <= hops_d;
      rtype_q  <= rtype_d;
      rclass_q <= rclass_d;
      rdlen_q  <= rdlen_d;
      acc_q    <= acc_d;
    end
  end

  assign res_vld_o = res_vld_d;
  assign res_o     = res_d;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= dnsa_pkg::CntW'(dnsa_pkg::MaxBytes)) else $error("byte count overran");

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take_i && item_i.last) |=> (phase_q == PhHdr && cnt_q == '0 && acc_q == '0))
    else $error("packet state not cleared after last byte");

  a_res_zero_ip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_vld_o && !res_o.found) |-> res_o.ip == 32'd0) else $error("ip set without a hit");

endmodule

/* src/dnsa_out_reg.sv */
module dnsa_out_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           res_vld_i,
  input  dnsa_pkg::res_t res_i,
  output logic           ready_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic           found_o,
  output logic [31:0]    ip_address_o
);

  logic           vld_q, vld_d;
  dnsa_pkg::res_t res_q;

  assign ready_o = ~vld_q | ~out_stall_i;
  assign vld_d   = res_vld_i | (vld_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_vld_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o  = vld_q;
  assign found_o      = res_q.found;
  assign ip_address_o = res_q.ip;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_i |-> ready_o) else $error("result loaded over a held result");

endmodule

/* src/dns_a_record_parser.sv */
// DNS response A-record parser.
// Input channel: one packet byte per transfer on data_byte_i, with
// last_byte_i set on the final byte. in_valid_i / in_stall_o handshake.
// Output channel: exactly one result per packet (found_o, ip_address_o),
// transferred on out_valid_o / out_stall_i after the last byte.
// Config: cfg_we_i writes cfg_wdata_i as the expected transaction id;
// write only while no packet is in flight.
// Throughput: one byte per cycle while in_stall_o is low. Each byte passes
// an input register and is then parsed by the header/name/record field logic.
// A result is loaded into the output register when the parser takes its last byte.
// When the receiver stalls with a result held, the block keeps taking
// non-final bytes; the next last byte waits in the input register until
// the output register frees, and in_stall_o rises meanwhile.
// Reset clears the parser to the start of a packet, empties both
// registers and sets the expected id to zero.
module dns_a_record_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        found_o,
  output logic [31:0] ip_address_o
);

  logic            in_vld;
  dnsa_pkg::item_t in_item;
  logic            out_ready;
  logic            take;
  logic            res_vld;
  dnsa_pkg::res_t  res;

  assign take = in_vld & (~in_item.last | out_ready);

  dnsa_in_reg u_in_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .in_stall_o  (in_stall_o),
    .drain_i     (take),
    .vld_o       (in_vld),
    .item_o      (in_item)
  );

  dnsa_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .take_i      (take),
    .item_i      (in_item),
    .res_vld_o   (res_vld),
    .res_o       (res)
  );

  dnsa_out_reg u_out_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .res_vld_i    (res_vld),
    .res_i        (res),
    .ready_o      (out_ready),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .found_o      (found_o),
    .ip_address_o (ip_address_o)
  );

endmodule
